### hdl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types and constants of the next-fit bitmap id allocator
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int ID_W     = 7;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } state_t;

  // commands into the used map
  typedef struct packed {
    logic set;
    logic clr;
  } map_cmd_t;

  // scanner status toward the control fsm
  typedef struct packed {
    logic hit;
    logic exhausted;
  } scan_stat_t;

endpackage

### hdl/nfa_if.sv
// ----------------------------------------------------------------------------
// nfa_req_if / nfa_rsp_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
interface nfa_req_if import nfa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [ID_W-1:0] free_id;

  modport source (output valid, output op, output free_id, input ready);
  modport sink   (input valid, input op, input free_id, output ready);
endinterface

interface nfa_rsp_if import nfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

### hdl/nfa_map.sv
// ----------------------------------------------------------------------------
// nfa_map
// used-slot bit map with one set port, one clear port and two bit reads
// ----------------------------------------------------------------------------
module nfa_map import nfa_pkg::*; #(
  parameter int NUM_IDS = 64,
  parameter int SW      = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  map_cmd_t      cmd,
  input  logic [SW-1:0] set_idx,
  input  logic [SW-1:0] clr_idx,
  input  logic [SW-1:0] scan_idx,
  input  logic [SW-1:0] free_idx,
  output logic          scan_busy,
  output logic          free_busy
);

  logic [NUM_IDS-1:0] used_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else begin
      if (cmd.set) used_map[set_idx] <= 1'b1;
      if (cmd.clr) used_map[clr_idx] <= 1'b0;
    end
  end

  assign scan_busy = used_map[scan_idx];
  assign free_busy = used_map[free_idx];

endmodule

### hdl/nfa_scan.sv
// ----------------------------------------------------------------------------
// nfa_scan
// serial circular search, one slot per cycle from the slot after last grant
// ----------------------------------------------------------------------------
module nfa_scan import nfa_pkg::*; #(
  parameter int NUM_IDS = 64,
  parameter int SW      = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  output logic [SW-1:0] slot,
  output scan_stat_t    stat
);

  localparam logic [SW-1:0] LAST = SW'(NUM_IDS - 1);

  logic [SW-1:0] last_slot;
  logic [SW-1:0] cnt;
  logic          active;
  logic [SW-1:0] after_last;
  logic [SW-1:0] slot_inc;

  assign after_last = (last_slot == LAST) ? '0 : last_slot + SW'(1);
  assign slot_inc   = (slot == LAST) ? '0 : slot + SW'(1);

  assign stat.hit       = active && !busy;
  assign stat.exhausted = active && busy && (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_slot <= '0;
      active    <= 1'b0;
      cnt       <= '0;
      slot      <= '0;
    end else if (start) begin
      slot   <= after_last;
      cnt    <= '0;
      active <= 1'b1;
    end else if (active) begin
      if (!busy) begin
        last_slot <= slot;
        active    <= 1'b0;
      end else if (cnt == LAST) begin
        active <= 1'b0;
      end else begin
        slot <= slot_inc;
        cnt  <= cnt + SW'(1);
      end
    end
  end

endmodule

### hdl/next_fit_bitmap_id_allocator_top.sv
// ----------------------------------------------------------------------------
// next_fit_bitmap_id_allocator_top
// allocate: the scanner probes k slots, k from 1 to NUM_IDS, one slot per
//   cycle, and the result is captured when a free slot is found or all are busy
// free needs no scan; the control takes one request at a time, and the
//   output register lets a result wait for ready
// reset: synchronous, clears the used map, the last-grant slot and all control
// ----------------------------------------------------------------------------
module next_fit_bitmap_id_allocator_top import nfa_pkg::*; #(
  parameter int NUM_IDS = 64
) (
  input logic       clk,
  input logic       rst,
  nfa_req_if.sink   req,
  nfa_rsp_if.source rsp
);

  // slot index width follows the pool size
  localparam int SW = $clog2(NUM_IDS);

  state_t state, state_next;

  // captured request word
  logic            op_q;
  logic [ID_W-1:0] fid_q;

  // result waiting for the output register
  logic [ID_W-1:0]     res_id;
  logic [STATUS_W-1:0] res_status;

  logic          accept;
  logic          start;
  logic [SW-1:0] slot;
  scan_stat_t    stat;
  logic          scan_busy;
  logic          free_busy;
  map_cmd_t      cmd;

  // free request decode
  logic [ID_W-1:0] fid_m1;
  logic [SW-1:0]   free_idx;
  logic            fid_in_range;
  logic            free_ok;

  assign fid_m1       = fid_q - ID_W'(1);
  assign free_idx     = fid_m1[SW-1:0];
  assign fid_in_range = (fid_q != '0) && (fid_q <= ID_W'(NUM_IDS));
  assign free_ok      = fid_in_range && free_busy;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign start     = accept && (req.op == OP_ALLOC);

  nfa_map #(
    .NUM_IDS (NUM_IDS),
    .SW      (SW)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .set_idx   (slot),
    .clr_idx   (free_idx),
    .scan_idx  (slot),
    .free_idx  (free_idx),
    .scan_busy (scan_busy),
    .free_busy (free_busy)
  );

  nfa_scan #(
    .NUM_IDS (NUM_IDS),
    .SW      (SW)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (scan_busy),
    .slot  (slot),
    .stat  (stat)
  );

  // next state and map commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (req.op == OP_ALLOC) ? ST_SCAN : ST_FREE;
      end
      ST_SCAN: begin
        // slot is marked the same cycle the scanner finds it free
        cmd.set = stat.hit;
        if (stat.hit || stat.exhausted) state_next = ST_DONE;
      end
      ST_FREE: begin
        cmd.clr    = free_ok;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // capture of request word and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.op;
      fid_q <= req.free_id;
    end
    if (state == ST_SCAN && stat.hit) begin
      res_id     <= ID_W'(slot) + ID_W'(1);
      res_status <= STATUS_OK;
    end else if (state == ST_SCAN && stat.exhausted) begin
      res_id     <= '0;
      res_status <= STATUS_EXHAUSTED;
    end else if (state == ST_FREE) begin
      res_id     <= '0;
      res_status <= (op_q == OP_FREE && free_ok) ? STATUS_OK : STATUS_BAD_FREE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.granted_id <= res_id;
      rsp.status     <= res_status;
    end
  end

endmodule
